>>> rtl/xlb_pkg.sv
`timescale 1ns / 1ps
// xlb_pkg: shared types, field widths and microcode ROM for the XOR linear basis.
// Depends on nothing; every rtl file imports it.
package xlb_pkg;

	localparam int XLB_WORD_BITS = 63;
	localparam int VALUE_BITS    = 63;
	localparam int MAX_XOR_BITS  = 63;
	localparam int RANK_BITS     = 6;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_QUERY  = 1'b1
	} op_t;

	typedef struct packed {
		logic                  opcode;
		logic [VALUE_BITS-1:0] value;
	} req_t;

	typedef struct packed {
		logic [MAX_XOR_BITS-1:0] max_xor;
		logic                    was_independent;
		logic [RANK_BITS-1:0]    rank;
	} res_t;

	// Microcode step addresses
	typedef logic [3:0] step_t;
	localparam step_t STEP_IDLE    = 4'd0;
	localparam step_t STEP_PRE     = 4'd1;
	localparam step_t STEP_LOOP    = 4'd2;
	localparam step_t STEP_DRAIN   = 4'd3;
	localparam step_t STEP_E_PRE   = 4'd4;
	localparam step_t STEP_E_LOOP  = 4'd5;
	localparam step_t STEP_E_DRAIN = 4'd6;
	localparam step_t STEP_STORE   = 4'd7;
	localparam step_t STEP_DONE    = 4'd8;

	typedef enum logic [1:0] {
		COND_ALWAYS   = 2'd0,
		COND_START    = 2'd1,
		COND_IDX_ZERO = 2'd2,
		COND_NO_STORE = 2'd3
	} cond_t;

	typedef enum logic [1:0] {
		PROC_NONE = 2'd0,
		PROC_SCAN = 2'd1,
		PROC_ELIM = 2'd2
	} proc_t;

	// One control word
	typedef struct packed {
		logic  idle;
		logic  dec_idx;
		proc_t proc;
		logic  store;
		logic  done;
		cond_t cond;
		step_t jump;
		step_t next;
	} ucode_t;

	// Datapath status seen by the jump logic
	typedef struct packed {
		logic idx_zero;
		logic no_store;
	} status_t;

	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		w = '0;
		w.proc = PROC_NONE;
		w.cond = COND_ALWAYS;
		w.jump = STEP_IDLE;
		w.next = STEP_IDLE;
		unique case (step)
			STEP_IDLE: begin
				w.idle = 1'b1;
				w.cond = COND_START;
				w.jump = STEP_PRE;
				w.next = STEP_IDLE;
			end
			STEP_PRE: begin
				w.dec_idx = 1'b1;
				w.jump    = STEP_LOOP;
			end
			STEP_LOOP: begin
				w.dec_idx = 1'b1;
				w.proc    = PROC_SCAN;
				w.cond    = COND_IDX_ZERO;
				w.jump    = STEP_DRAIN;
				w.next    = STEP_LOOP;
			end
			STEP_DRAIN: begin
				w.proc = PROC_SCAN;
				w.jump = STEP_E_PRE;
			end
			STEP_E_PRE: begin
				w.dec_idx = 1'b1;
				w.cond    = COND_NO_STORE;
				w.jump    = STEP_DONE;
				w.next    = STEP_E_LOOP;
			end
			STEP_E_LOOP: begin
				w.dec_idx = 1'b1;
				w.proc    = PROC_ELIM;
				w.cond    = COND_IDX_ZERO;
				w.jump    = STEP_E_DRAIN;
				w.next    = STEP_E_LOOP;
			end
			STEP_E_DRAIN: begin
				w.proc = PROC_ELIM;
				w.jump = STEP_STORE;
			end
			STEP_STORE: begin
				w.store = 1'b1;
				w.jump  = STEP_DONE;
			end
			STEP_DONE: begin
				w.done = 1'b1;
				w.jump = STEP_IDLE;
			end
			default: begin
				w.jump = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

>>> rtl/xlb_mem.sv
`timescale 1ns / 1ps
// xlb_mem: basis storage, one slot per leading bit, with per-slot valid flags.
// Depends on xlb_pkg. One write port, one registered read port.
module xlb_mem
	import xlb_pkg::*;
#(
	parameter int WORD_BITS = XLB_WORD_BITS,
	localparam int IDX_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 we,
	input  logic                 mark,
	input  logic [IDX_W-1:0]     waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic [IDX_W-1:0]     raddr,
	output logic [WORD_BITS-1:0] ent,
	output logic                 ent_valid,
	output logic [IDX_W-1:0]     ent_idx
);

	logic [WORD_BITS-1:0] mem [WORD_BITS];
	logic [WORD_BITS-1:0] valid_q;
	logic [WORD_BITS-1:0] rdata_s1;
	logic                 rvalid_s1;
	logic [IDX_W-1:0]     ridx_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
		ridx_s1  <= raddr;
	end

	// empty slots read as zero via the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (we && mark) begin
				valid_q[waddr] <= 1'b1;
			end
			rvalid_s1 <= valid_q[raddr];
		end
	end

	assign ent       = rvalid_s1 ? rdata_s1 : '0;
	assign ent_valid = rvalid_s1;
	assign ent_idx   = ridx_s1;

endmodule

>>> rtl/xlb_seq.sv
`timescale 1ns / 1ps
// xlb_seq: microcode step counter, control ROM lookup and conditional jumps.
// Depends on xlb_pkg (ucode_rom, ucode_t, status_t).
module xlb_seq
	import xlb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output ucode_t  ctrl
);

	step_t step_q;
	step_t step_d;
	logic  taken;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		ctrl = ucode_rom(step_q);
		unique case (ctrl.cond)
			COND_ALWAYS:   taken = 1'b1;
			COND_START:    taken = start;
			COND_IDX_ZERO: taken = status.idx_zero;
			COND_NO_STORE: taken = status.no_store;
			default:       taken = 1'b1;
		endcase
		step_d = taken ? ctrl.jump : ctrl.next;
	end

endmodule

>>> rtl/xlb_dp.sv
`timescale 1ns / 1ps
// xlb_dp: working word, slot index counter, leading-bit tracker and rank.
// Depends on xlb_pkg; driven by the control word from xlb_seq.
module xlb_dp
	import xlb_pkg::*;
#(
	parameter int WORD_BITS = XLB_WORD_BITS,
	localparam int IDX_W  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1,
	localparam int RANK_W = $clog2(WORD_BITS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ucode_t               ctrl,
	input  logic                 start,
	input  req_t                 req,
	input  logic [WORD_BITS-1:0] ent,
	input  logic                 ent_valid,
	input  logic [IDX_W-1:0]     ent_idx,
	output logic [IDX_W-1:0]     raddr,
	output logic                 we,
	output logic [IDX_W-1:0]     waddr,
	output logic [WORD_BITS-1:0] wdata,
	output status_t              status,
	output res_t                 res
);

	localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(WORD_BITS - 1);

	logic [WORD_BITS-1:0] x_q, x_d;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     lead_q, lead_d;
	logic                 found_q, found_d;
	logic                 indep_q;
	logic [RANK_W-1:0]    rank_q;
	op_t                  op_q;
	logic                 load;
	logic                 xbit;

	assign load = ctrl.idle && start;
	assign xbit = x_q[ent_idx];

	always_comb begin
		x_d     = x_q;
		lead_d  = lead_q;
		found_d = found_q;
		if (ctrl.proc == PROC_SCAN) begin
			if (op_q == OP_QUERY) begin
				if (ent_valid && !xbit) begin
					x_d = x_q ^ ent;
				end
			end else begin
				if (ent_valid && xbit) begin
					x_d = x_q ^ ent;
				end
				// bit of an empty slot survives: first one from the top is the lead
				if (!ent_valid && xbit && !found_q) begin
					found_d = 1'b1;
					lead_d  = ent_idx;
				end
			end
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = lead_q;
		wdata = x_q;
		if (ctrl.store) begin
			we = 1'b1;
		end else if (ctrl.proc == PROC_ELIM && ent_valid && ent[lead_q]) begin
			we    = 1'b1;
			waddr = ent_idx;
			wdata = ent ^ x_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q    <= WORD_BITS'(req.value);
			op_q   <= op_t'(req.opcode);
			lead_q <= '0;
		end else begin
			x_q    <= x_d;
			lead_q <= lead_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= IDX_TOP;
			found_q <= 1'b0;
			indep_q <= 1'b0;
			rank_q  <= '0;
		end else begin
			if (load) begin
				idx_q   <= IDX_TOP;
				found_q <= 1'b0;
				indep_q <= 1'b0;
			end else begin
				found_q <= found_d;
				if (ctrl.dec_idx) begin
					idx_q <= (idx_q == '0) ? IDX_TOP : idx_q - 1'b1;
				end
				if (ctrl.store) begin
					indep_q <= 1'b1;
					rank_q  <= rank_q + 1'b1;
				end
			end
		end
	end

	assign raddr           = idx_q;
	assign status.idx_zero = (idx_q == '0);
	assign status.no_store = (op_q == OP_QUERY) || !found_q;

	assign res.max_xor         = (op_q == OP_QUERY) ? MAX_XOR_BITS'(x_q) : '0;
	assign res.was_independent = indep_q;
	assign res.rank            = RANK_BITS'(rank_q);

endmodule

>>> rtl/xor_linear_basis_top.sv
`timescale 1ns / 1ps
// xor_linear_basis_top: fully reduced GF(2) linear basis with insert and max-xor query.
// Depends on xlb_pkg, xlb_mem, xlb_seq and xlb_dp.
//
// Usage:
//   Request channel: drive req (opcode, value) and raise start; the request is
//   taken at the clock edge where start is high and busy is low. busy stays high
//   until the result has been shown.
//   Result channel: done is high for exactly one cycle with res (max_xor,
//   was_independent, rank) valid in that cycle. The receiver cannot stall it;
//   a result not captured in that cycle is gone.
//   Operation: a microcoded sequencer walks the basis memory one slot per cycle
//   through its single read port. A query walks every slot once, from the top
//   slot down to slot 0, and then shows done; a zero or dependent insert takes
//   the same path. An independent insert adds an elimination walk over every
//   slot plus the store before done. A new request is taken only once the
//   sequencer is back at idle after done.
//   Reset: arst_n clears the slot valid flags, the rank and the sequencer at
//   once; the basis is empty and a request can be taken right after release.
//   No clearing pass is needed.
module xor_linear_basis_top
	import xlb_pkg::*;
#(
	parameter int WORD_BITS = XLB_WORD_BITS,
	localparam int IDX_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output res_t res
);

	ucode_t               ctrl;
	status_t              status;
	logic [IDX_W-1:0]     raddr;
	logic                 we;
	logic [IDX_W-1:0]     waddr;
	logic [WORD_BITS-1:0] wdata;
	logic [WORD_BITS-1:0] ent;
	logic                 ent_valid;
	logic [IDX_W-1:0]     ent_idx;

	// sequencer: step counter and control ROM
	xlb_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.ctrl   (ctrl)
	);

	// datapath: working word, lead tracking, rank and write-port mux
	xlb_dp #(
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.start     (start),
		.req       (req),
		.ent       (ent),
		.ent_valid (ent_valid),
		.ent_idx   (ent_idx),
		.raddr     (raddr),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.status    (status),
		.res       (res)
	);

	// basis slots: entry i holds the vector whose leading bit is i
	xlb_mem #(
		.WORD_BITS (WORD_BITS)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.we        (we),
		.mark      (ctrl.store),
		.waddr     (waddr),
		.wdata     (wdata),
		.raddr     (raddr),
		.ent       (ent),
		.ent_valid (ent_valid),
		.ent_idx   (ent_idx)
	);

	assign busy = !ctrl.idle;
	assign done = ctrl.done;

	// a result always closes a request: sequencer is back at idle next cycle
	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("sequencer did not return to idle after result");

	// an accepted request occupies the block, no result in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted request did not start the sequencer");

	// a new basis vector means an insert: zero answer and a nonzero rank
	a_indep_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.was_independent) |->
		((res.max_xor == MAX_XOR_BITS'(0)) && (res.rank != RANK_BITS'(0))))
		else $error("independent flag on a query or with zero rank");

	// results come only out of a running request
	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in flight");

endmodule
